// ----- rtl/pfd_pkg.sv -----
package pfd_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 64;

  // fixed field widths of the ports
  localparam int CODE_W = 7;
  localparam int VERT_W = 6;
  localparam int CFG_W  = 7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CNT_RD,
    ST_CNT_OCC,
    ST_CNT_WR,
    ST_BUILD,
    ST_DEC_RD,
    ST_DEC_OCC,
    ST_DEC_EMIT,
    ST_PAIR_A,
    ST_PAIR_B,
    ST_ERR
  } state_t;

  // commands from the sequencer to the leaf unit
  typedef struct packed {
    logic clear;       // start of decode: drop seen bits and leaf map
    logic occ_rd;      // read occurrence count at addr
    logic count_wr;    // occurrence count at addr plus one, mark seen
    logic build;       // leaf map from range and seen bits
    logic remove;      // retire lowest leaf, decrement addr
    logic take_first;  // retire lowest leaf only
  } leaf_cmd_t;

endpackage

// ----- rtl/prufer_tree_decoder_core.sv -----
// Loading: one word per cycle; busy stays low between words, so words may come back to back.
// Final word, code length c = n-2: busy through count pass, leaf-map build, decode and last pair;
// one registered edge strobe per decode entry, then the last edge from the pair states.
// One priority encoder sits behind registered store and occurrence reads: each entry is read, looked up, then emitted.
// Error: one strobe, from the final word checks, or from the count pass for an entry > n; results cannot be stalled.
// Reset (rst, synchronous): vertex_count back to 2, loader and sequencer idle, stores undefined.
module prufer_tree_decoder_core #(
  parameter int MAX_VERTICES = pfd_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pfd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input words
  input  logic                         start,
  output logic                         busy,
  input  logic [pfd_pkg::CODE_W-1:0]   code_vertex,
  input  logic [WEIGHT_BITS-1:0]       edge_weight,
  input  logic                         final_item,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfd_pkg::CFG_W-1:0]    cfg_data,
  // result words
  output logic                         result_strobe,
  output logic [pfd_pkg::VERT_W-1:0]   leaf_vertex,
  output logic [pfd_pkg::VERT_W-1:0]   other_vertex,
  output logic [WEIGHT_BITS-1:0]       weight_out,
  output logic                         last_edge,
  output logic                         bad_code
);

  localparam int CFG_W    = pfd_pkg::CFG_W;
  localparam int CODE_W   = pfd_pkg::CODE_W;
  localparam int VERT_W   = pfd_pkg::VERT_W;
  // vertex index width, and counter width that holds the code capacity
  localparam int VW       = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW       = VW + 1;
  localparam int CODE_CAP = MAX_VERTICES - 2;
  localparam int DEPTH    = (CODE_CAP > 0) ? CODE_CAP : 1;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW       = VW;

  localparam logic [CW-1:0]     CAP_CNT = CW'(CODE_CAP);
  localparam logic [CODE_W-1:0] MAX_CV  = CODE_W'(MAX_VERTICES);
  localparam logic [CFG_W-1:0]  MAX_N   = CFG_W'(MAX_VERTICES);

  pfd_pkg::state_t    state, state_next;
  pfd_pkg::leaf_cmd_t leaf_cmd;

  logic [CFG_W-1:0]       vertex_count;
  logic [CW-1:0]          item_count, item_count_next;
  logic                   error_seen, error_seen_next;
  logic [CW-1:0]          idx, idx_next;
  logic [WEIGHT_BITS-1:0] last_weight;
  logic                   last_weight_en;
  logic [VW-1:0]          pair_a;
  logic                   pair_a_en;

  // code/weight store
  logic                   st_wr_en;
  logic                   st_rd_en;
  logic [VW-1:0]          rd_code;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [CODE_W-1:0]      cv_m1;

  // leaf unit
  logic [OW-1:0]          occ_rdata;
  logic [VW-1:0]          low_leaf;

  // result register inputs
  logic                   emit;
  logic [VERT_W-1:0]      leaf_vertex_next;
  logic [VERT_W-1:0]      other_vertex_next;
  logic [WEIGHT_BITS-1:0] weight_out_next;
  logic                   last_edge_next;
  logic                   bad_code_next;

  logic                   accept;
  logic                   cnt_last;
  logic                   pre_bad;
  logic                   code_oor;

  assign busy      = (state != pfd_pkg::ST_LOAD);
  assign accept    = start && !busy;
  // vertex count is used all through a decode: no writes while busy
  assign cfg_ready = !busy;
  assign cv_m1     = code_vertex - CODE_W'(1);
  assign cnt_last  = (idx == item_count - CW'(1));

  // checks known when the final word arrives
  assign pre_bad = error_seen || (vertex_count < CFG_W'(2)) || (vertex_count > MAX_N) ||
                   (CFG_W'(item_count) + CFG_W'(2) != vertex_count);

  // stored entry beyond the vertex range, seen in the count pass
  assign code_oor = (CFG_W'(rd_code) >= vertex_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  pfd_store #(
    .VW          (VW),
    .WEIGHT_BITS (WEIGHT_BITS),
    .DEPTH       (DEPTH),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (item_count[AW-1:0]),
    .wr_code   (cv_m1[VW-1:0]),
    .wr_weight (edge_weight),
    .rd_en     (st_rd_en),
    .rd_addr   (idx[AW-1:0]),
    .rd_code   (rd_code),
    .rd_weight (rd_weight)
  );

  pfd_leaf #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .OW           (OW)
  ) u_leaf (
    .clk          (clk),
    .rst          (rst),
    .cmd          (leaf_cmd),
    .addr         (rd_code),
    .vertex_count (vertex_count),
    .occ_rdata    (occ_rdata),
    .low_leaf     (low_leaf)
  );

  // sequencer: load, count pass, build leaf map, decode, last pair, or error result
  always_comb begin
    state_next        = state;
    item_count_next   = item_count;
    error_seen_next   = error_seen;
    idx_next          = idx;
    last_weight_en    = 1'b0;
    pair_a_en         = 1'b0;
    st_wr_en          = 1'b0;
    st_rd_en          = 1'b0;
    leaf_cmd          = '0;
    emit              = 1'b0;
    leaf_vertex_next  = '0;
    other_vertex_next = '0;
    weight_out_next   = '0;
    last_edge_next    = 1'b0;
    bad_code_next     = 1'b0;

    unique case (state)
      pfd_pkg::ST_LOAD: begin
        if (accept && !final_item) begin
          if (item_count >= CAP_CNT) begin
            // code already full: word dropped
            error_seen_next = 1'b1;
          end else begin
            if ((code_vertex == '0) || (code_vertex > MAX_CV)) begin
              error_seen_next = 1'b1;
            end
            st_wr_en        = 1'b1;
            item_count_next = item_count + CW'(1);
          end
        end else if (accept) begin
          last_weight_en = 1'b1;
          idx_next       = '0;
          leaf_cmd.clear = 1'b1;
          if (pre_bad) begin
            state_next = pfd_pkg::ST_ERR;
          end else if (item_count == '0) begin
            state_next = pfd_pkg::ST_BUILD;
          end else begin
            state_next = pfd_pkg::ST_CNT_RD;
          end
        end
      end

      pfd_pkg::ST_CNT_RD: begin
        st_rd_en   = 1'b1;
        state_next = pfd_pkg::ST_CNT_OCC;
      end

      pfd_pkg::ST_CNT_OCC: begin
        if (code_oor) begin
          state_next = pfd_pkg::ST_ERR;
        end else begin
          leaf_cmd.occ_rd = 1'b1;
          state_next      = pfd_pkg::ST_CNT_WR;
        end
      end

      pfd_pkg::ST_CNT_WR: begin
        leaf_cmd.count_wr = 1'b1;
        if (cnt_last) begin
          idx_next   = '0;
          state_next = pfd_pkg::ST_BUILD;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = pfd_pkg::ST_CNT_RD;
        end
      end

      pfd_pkg::ST_BUILD: begin
        leaf_cmd.build = 1'b1;
        state_next     = (item_count == '0) ? pfd_pkg::ST_PAIR_A : pfd_pkg::ST_DEC_RD;
      end

      pfd_pkg::ST_DEC_RD: begin
        st_rd_en   = 1'b1;
        state_next = pfd_pkg::ST_DEC_OCC;
      end

      pfd_pkg::ST_DEC_OCC: begin
        leaf_cmd.occ_rd = 1'b1;
        state_next      = pfd_pkg::ST_DEC_EMIT;
      end

      pfd_pkg::ST_DEC_EMIT: begin
        // join lowest leaf to this code entry
        leaf_cmd.remove   = 1'b1;
        emit              = 1'b1;
        leaf_vertex_next  = VERT_W'(low_leaf);
        other_vertex_next = VERT_W'(rd_code);
        weight_out_next   = rd_weight;
        idx_next          = idx + CW'(1);
        state_next        = cnt_last ? pfd_pkg::ST_PAIR_A : pfd_pkg::ST_DEC_RD;
      end

      pfd_pkg::ST_PAIR_A: begin
        pair_a_en           = 1'b1;
        leaf_cmd.take_first = 1'b1;
        state_next          = pfd_pkg::ST_PAIR_B;
      end

      pfd_pkg::ST_PAIR_B: begin
        emit              = 1'b1;
        leaf_vertex_next  = VERT_W'(pair_a);
        other_vertex_next = VERT_W'(low_leaf);
        weight_out_next   = last_weight;
        last_edge_next    = 1'b1;
        item_count_next   = '0;
        error_seen_next   = 1'b0;
        state_next        = pfd_pkg::ST_LOAD;
      end

      pfd_pkg::ST_ERR: begin
        emit            = 1'b1;
        last_edge_next  = 1'b1;
        bad_code_next   = 1'b1;
        item_count_next = '0;
        error_seen_next = 1'b0;
        state_next      = pfd_pkg::ST_LOAD;
      end

      default: begin
        state_next = pfd_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pfd_pkg::ST_LOAD;
      item_count    <= '0;
      error_seen    <= 1'b0;
      idx           <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      item_count    <= item_count_next;
      error_seen    <= error_seen_next;
      idx           <= idx_next;
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (last_weight_en) begin
      last_weight <= edge_weight;
    end
    if (pair_a_en) begin
      pair_a <= low_leaf;
    end
    if (emit) begin
      leaf_vertex  <= leaf_vertex_next;
      other_vertex <= other_vertex_next;
      weight_out   <= weight_out_next;
      last_edge    <= last_edge_next;
      bad_code     <= bad_code_next;
    end
  end

`ifndef ASSERT_OFF
  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state != pfd_pkg::ST_LOAD))
    else $error("result strobe without a decode in progress");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && bad_code) |-> last_edge)
    else $error("error result not marked as last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_edge) |-> !busy && (item_count == '0) && !error_seen)
    else $error("run state not cleared after last result");
`endif

endmodule

// ----- rtl/pfd_store.sv -----
module pfd_store #(
  parameter int VW          = 6,
  parameter int WEIGHT_BITS = pfd_pkg::WEIGHT_BITS_DEF,
  parameter int DEPTH       = 62,
  parameter int AW          = 6
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [VW-1:0]          wr_code,
  input  logic [WEIGHT_BITS-1:0] wr_weight,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [VW-1:0]          rd_code,
  output logic [WEIGHT_BITS-1:0] rd_weight
);

  logic [VW-1:0]          code_mem   [DEPTH];
  logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr]   <= wr_code;
      weight_mem[wr_addr] <= wr_weight;
    end
  end

  // registered read; held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_code   <= code_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/pfd_leaf.sv -----
module pfd_leaf #(
  parameter int MAX_VERTICES = pfd_pkg::MAX_VERTICES_DEF,
  parameter int VW           = 6,
  parameter int OW           = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pfd_pkg::leaf_cmd_t       cmd,
  input  logic [VW-1:0]            addr,
  input  logic [pfd_pkg::CFG_W-1:0] vertex_count,
  output logic [OW-1:0]            occ_rdata,
  output logic [VW-1:0]            low_leaf
);

  // occurrences left in the code per vertex (degree minus one)
  logic [OW-1:0]           occ_mem [MAX_VERTICES];
  logic [OW-1:0]           occ_raw;
  logic                    seen_q;
  logic [MAX_VERTICES-1:0] seen;
  logic [MAX_VERTICES-1:0] leaf_map;
  logic [MAX_VERTICES-1:0] leaf_map_next;
  logic [OW-1:0]           occ_wdata;

  // an entry never counted reads as zero
  assign occ_rdata = seen_q ? occ_raw : '0;
  assign occ_wdata = cmd.count_wr ? occ_rdata + OW'(1) : occ_rdata - OW'(1);

  always_ff @(posedge clk) begin
    if (cmd.occ_rd) begin
      occ_raw <= occ_mem[addr];
      seen_q  <= seen[addr];
    end
    if (cmd.count_wr || cmd.remove) begin
      occ_mem[addr] <= occ_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      seen <= '0;
    end else if (cmd.count_wr) begin
      seen[addr] <= 1'b1;
    end
  end

  // shared priority encoder: lowest set bit of the leaf map
  always_comb begin
    low_leaf = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (leaf_map[i]) begin
        low_leaf = VW'(i);
      end
    end
  end

  always_comb begin
    leaf_map_next = leaf_map;
    if (cmd.clear) begin
      leaf_map_next = '0;
    end else if (cmd.build) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        leaf_map_next[i] = (pfd_pkg::CFG_W'(i) < vertex_count) && !seen[i];
      end
    end else if (cmd.remove) begin
      leaf_map_next[low_leaf] = 1'b0;
      if (occ_rdata == OW'(1)) begin
        leaf_map_next[addr] = 1'b1;
      end
    end else if (cmd.take_first) begin
      leaf_map_next[low_leaf] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_map <= '0;
    end else begin
      leaf_map <= leaf_map_next;
    end
  end

`ifndef ASSERT_OFF
  // a code vertex still referenced can never sit in the leaf map
  a_parent_not_leaf: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> (leaf_map != '0) && !leaf_map[addr])
    else $error("leaf unit: no leaf or parent marked leaf on removal");
`endif

endmodule
